@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the timer wheel RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TWE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define TWE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ rtl/core/twe_pkg.sv @@
// ----------------------------------------------------------------------------
// twe_pkg
// Types, constants and codes shared by the timer wheel expiry block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package twe_pkg;

  localparam int NUM_TIMERS_DEF = 64;
  localparam int CMD_W          = 2;
  localparam int ID_W           = 6;
  localparam int INTERVAL_W     = 31;
  localparam int COUNT_W        = 8;
  localparam int SHIFT_W        = 5;
  localparam int SLICE_W        = 32;
  localparam int ARMED_CNT_W    = 7;
  localparam int MAX_RESULTS    = 64;
  localparam int RES_CNT_W      = $clog2(MAX_RESULTS);

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(9);

  localparam logic [CMD_W-1:0] CMD_ARM    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DISARM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [ID_W-1:0]       timer_id;
    logic [INTERVAL_W-1:0] interval_ms;
    logic [COUNT_W-1:0]    slice_count;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] expired_id;
    logic            last_expired;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic arm;
    logic disarm;
    logic tick_start;
    logic scan_start;
    logic emit;
    logic finish;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic running;
    logic scan_done;
    logic found;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/twe_ram.sv @@
// ----------------------------------------------------------------------------
// twe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twe_ram #(
  parameter int WIDTH = twe_pkg::SLICE_W,
  parameter int DEPTH = twe_pkg::NUM_TIMERS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/twe_datapath.sv @@
// ----------------------------------------------------------------------------
// twe_datapath
// Timer table, slice clock, expiry scan unit and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module twe_datapath #(
  parameter int NUM_TIMERS = twe_pkg::NUM_TIMERS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [twe_pkg::SHIFT_W-1:0]  cfg_wr_data,
  input  wire twe_pkg::in_item_t            in_item,
  input  wire twe_pkg::ctrl_cmd_t           cmd,
  output twe_pkg::dp_status_t               sts,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output twe_pkg::out_item_t                out_item
);

  import twe_pkg::*;

  localparam int IDX_W = $clog2(NUM_TIMERS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  logic [SHIFT_W-1:0]     slice_shift;
  logic [SLICE_W-1:0]     now_slice;
  logic [ARMED_CNT_W-1:0] armed_count;
  logic                   running;
  logic [NUM_TIMERS-1:0]  armed;

  logic [SLICE_W-1:0]     old_slice;
  logic [COUNT_W-1:0]     tick_count;
  logic [IDX_W-1:0]       scan_idx;
  logic                   issuing;
  logic                   rd_pend;
  logic [IDX_W-1:0]       rd_idx;
  logic                   scan_done;
  logic                   found;
  logic                   multi;
  logic [IDX_W-1:0]       best_idx;
  logic [COUNT_W-1:0]     best_off;
  logic [RES_CNT_W-1:0]   res_cnt;

  logic [IDX_W-1:0]       in_idx;
  logic                   in_range;
  logic                   idle_start;
  logic [SLICE_W-1:0]     now_eff;
  logic [SLICE_W-1:0]     shifted;
  logic [SLICE_W-1:0]     arm_dl;
  logic [SLICE_W-1:0]     rd_data;
  logic [SLICE_W-1:0]     off;
  logic                   cand;
  logic                   better;

  assign in_idx     = IDX_W'(in_item.timer_id);
  assign in_range   = 32'(in_item.timer_id) < 32'(NUM_TIMERS);
  assign idle_start = (armed_count == '0) && !running;
  assign now_eff    = idle_start ? SLICE_W'(1) : now_slice;
  assign shifted    = {1'b0, in_item.interval_ms} >> slice_shift;
  assign arm_dl     = shifted + SLICE_W'(1) + now_eff;

  twe_ram #(
    .WIDTH (SLICE_W),
    .DEPTH (NUM_TIMERS)
  ) u_deadline (
    .clk     (clk),
    .wr_en   (cmd.arm && in_range),
    .wr_addr (in_idx),
    .wr_data (arm_dl),
    .rd_en   (issuing),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  // due: deadline in [old, old + count); strict less keeps the lowest id on ties
  assign off    = rd_data - old_slice;
  assign cand   = rd_pend && armed[rd_idx] && (off[SLICE_W-1:COUNT_W] == '0) &&
                  (off[COUNT_W-1:0] < tick_count);
  assign better = cand && (!found || (off[COUNT_W-1:0] < best_off));

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_shift <= SHIFT_RESET;
      now_slice   <= '0;
      armed_count <= '0;
      running     <= 1'b0;
      armed       <= '0;
      scan_idx    <= '0;
      issuing     <= 1'b0;
      rd_pend     <= 1'b0;
      scan_done   <= 1'b0;
      found       <= 1'b0;
      multi       <= 1'b0;
      res_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slice_shift <= cfg_wr_data;
      end

      if (cmd.arm && in_range) begin
        if (idle_start) begin
          running   <= 1'b1;
          now_slice <= SLICE_W'(1);
        end
        armed[in_idx] <= 1'b1;
        if (!armed[in_idx]) begin
          armed_count <= armed_count + ARMED_CNT_W'(1);
        end
      end

      if (cmd.disarm && in_range && armed[in_idx]) begin
        armed[in_idx] <= 1'b0;
        armed_count   <= armed_count - ARMED_CNT_W'(1);
      end

      if (cmd.tick_start) begin
        now_slice <= now_slice + SLICE_W'(in_item.slice_count);
        res_cnt   <= '0;
      end

      if (cmd.scan_start) begin
        scan_idx  <= '0;
        issuing   <= 1'b1;
        scan_done <= 1'b0;
        found     <= 1'b0;
        multi     <= 1'b0;
      end else if (issuing) begin
        scan_idx <= scan_idx + IDX_W'(1);
        if (scan_idx == LAST_IDX) begin
          issuing <= 1'b0;
        end
      end
      rd_pend <= issuing;

      if (cand) begin
        found <= 1'b1;
        if (found) begin
          multi <= 1'b1;
        end
      end
      if (rd_pend && (rd_idx == LAST_IDX)) begin
        scan_done <= 1'b1;
      end

      if (cmd.emit) begin
        armed[best_idx] <= 1'b0;
        armed_count     <= armed_count - ARMED_CNT_W'(1);
        res_cnt         <= res_cnt + RES_CNT_W'(1);
      end

      if (cmd.finish && (armed_count == '0)) begin
        running <= 1'b0;
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      old_slice  <= now_slice;
      tick_count <= in_item.slice_count;
    end
    rd_idx <= scan_idx;
    if (better) begin
      best_idx <= rd_idx;
      best_off <= off[COUNT_W-1:0];
    end
    if (cmd.emit) begin
      out_item.expired_id   <= ID_W'(best_idx);
      out_item.last_expired <= sts.last;
    end
  end

  always_comb begin
    sts.running   = running;
    sts.scan_done = scan_done;
    sts.found     = found;
    sts.last      = !multi || (res_cnt == RES_CNT_W'(MAX_RESULTS - 1));
  end

  `TWE_ASSERT_IMP(a_emit_free, clk, rst, cmd.emit, !out_valid || out_ready)
  `TWE_ASSERT_IMP(a_emit_armed, clk, rst, cmd.emit, armed[best_idx])
  `TWE_ASSERT_IMP(a_scan_quiet, clk, rst, scan_done, !issuing && !rd_pend)
  `TWE_ASSERT_NXT(a_goes_idle, clk, rst, cmd.finish && (armed_count == '0), !running)

endmodule

`default_nettype wire

@@ rtl/core/twe_ctrl.sv @@
// ----------------------------------------------------------------------------
// twe_ctrl
// Command sequencer: immediate arm/disarm, tick scan passes, expiry emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module twe_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [twe_pkg::CMD_W-1:0]   command,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire twe_pkg::dp_status_t         sts,
  output twe_pkg::ctrl_cmd_t               cmd
);

  import twe_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_ARM:    cmd.arm = 1'b1;
            CMD_DISARM: cmd.disarm = 1'b1;
            CMD_TICK: begin
              if (sts.running) begin
                cmd.tick_start = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = sts.found ? S_EMIT : S_DONE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_next = S_DONE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `TWE_ASSERT_IMP(a_emit_has_hit, clk, rst, state == S_EMIT, sts.found)
  `TWE_ASSERT_NXT(a_miss_done, clk, rst, (state == S_SCAN) && sts.scan_done && !sts.found,
                  state == S_DONE)

endmodule

`default_nettype wire

@@ rtl/core/timer_wheel_expiry.sv @@
// Arm and disarm items are applied in their accept cycle and leave the block idle,
// ready for the next item. A tick runs one scan pass of the table per expired timer
// (one pass if none expire), each followed by emitting its result, then a closing
// state; the passes are set by the single read port of the deadline RAM. Output
// stalls lengthen a tick. Reset is synchronous; all timers disarmed, slice clock
// zero, slice_shift 9, no clearing pass.
// ----------------------------------------------------------------------------
// timer_wheel_expiry
// Coarse timer table: arm, disarm and tick items, expiries reported in
// deadline order with ties broken by ascending timer number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timer_wheel_expiry #(
  parameter int NUM_TIMERS = twe_pkg::NUM_TIMERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // slice_shift register
  input  wire logic                        cfg_wr_en,
  input  wire logic [twe_pkg::SHIFT_W-1:0] cfg_wr_data,
  // command items
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire twe_pkg::in_item_t           in_item,
  // expiry items
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output twe_pkg::out_item_t               out_item
);

  import twe_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequencer. Arm/disarm act in the accept cycle. A tick is a series of full
  // table scans; each pass picks the earliest due timer (lowest number on a
  // tie) and notes whether another is due, which flags the final item.
  twe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (in_item.command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: deadline RAM, armed bits, slice clock, scan compare and the
  // output register, which lets new commands in while an item waits.
  twe_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire
